// ----- design/obsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package obsc_pkg;

  localparam logic ACT_HOLD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  localparam int TURN_W       = 32;
  localparam int CORDIC_Q     = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;
  localparam int TRIG_BASE    = 59;
  localparam logic [31:0] CORDIC_START = 32'd652032874;

  function automatic logic [31:0] cordic_atan(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004757;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/obsc_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
module obsc_cordic
  import obsc_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [TURN_W-1:0]                     turn,
  output logic                                       done,
  output logic signed [TRIG_BASE-COORD_WIDTH+2:0]    cos_o,
  output logic signed [TRIG_BASE-COORD_WIDTH+2:0]    sin_o
);

  localparam int TRIG = TRIG_BASE - COORD_WIDTH;
  localparam int A_W  = TRIG + 3;
  localparam int XW   = 33;

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [31:0]   z;
  logic [1:0]           quad;
  logic [STEP_W-1:0]    step;
  logic                 busy;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [31:0]   at;
  logic signed [XW-1:0] cq;
  logic signed [XW-1:0] sq;

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign at = $signed(cordic_atan(step));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= $signed({1'b0, CORDIC_START});
      y    <= '0;
      z    <= $signed({2'b00, turn[CORDIC_Q-1:0]});
      quad <= turn[TURN_W-1:CORDIC_Q];
    end else if (busy) begin
      if (!z[31]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  always_comb begin
    case (quad)
      2'd0: begin
        cq = x;
        sq = y;
      end
      2'd1: begin
        cq = -y;
        sq = x;
      end
      2'd2: begin
        cq = -x;
        sq = -y;
      end
      default: begin
        cq = y;
        sq = -x;
      end
    endcase
  end

  generate
    if (TRIG >= CORDIC_Q) begin : g_up
      localparam int SH = TRIG - CORDIC_Q;
      logic signed [A_W-1:0] ce;
      logic signed [A_W-1:0] se;
      assign ce    = A_W'(cq);
      assign se    = A_W'(sq);
      assign cos_o = ce <<< SH;
      assign sin_o = se <<< SH;
    end else begin : g_down
      localparam int RS = CORDIC_Q - TRIG;
      localparam logic signed [XW:0] HALF = {{XW{1'b0}}, 1'b1} <<< (RS - 1);
      logic signed [XW:0] cr;
      logic signed [XW:0] sr;
      assign cr    = ($signed({cq[XW-1], cq}) + HALF) >>> RS;
      assign sr    = ($signed({sq[XW-1], sq}) + HALF) >>> RS;
      assign cos_o = cr[A_W-1:0];
      assign sin_o = sr[A_W-1:0];
    end
  endgenerate

endmodule
`default_nettype wire

// ----- design/obsc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module obsc_front
  import obsc_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          action,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] pivot_x,
  input  wire logic signed [COORD_WIDTH-1:0] pivot_y,
  input  wire logic [COORD_WIDTH-2:0]        width,
  input  wire logic [COORD_WIDTH-2:0]        height,
  input  wire logic [ANGLE_WIDTH-1:0]        angle,
  output logic                               job_valid,
  input  wire logic                          job_pop,
  output logic [2*(6*COORD_WIDTH-2+ANGLE_WIDTH)-1:0] job
);

  localparam int REC_W = 6 * COORD_WIDTH - 2 + ANGLE_WIDTH;
  localparam int ENT_W = 2 * REC_W;

  logic [REC_W-1:0] held;
  logic [ENT_W-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [REC_W-1:0] cur;
  logic             accept;
  logic             wr_en;

  assign cur       = {pos_x, pos_y, pivot_x, pivot_y, width, height, angle};
  assign full      = (count == 2'd2);
  assign job_valid = (count != 2'd0);
  assign job       = slot[rd_ptr];
  assign accept    = push && !full;
  assign wr_en     = accept && (action == ACT_TEST);

  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (accept && (action == ACT_HOLD)) begin
        held <= cur;
      end
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (job_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, job_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= {cur, held};
    end
  end

endmodule
`default_nettype wire

// ----- design/obsc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module obsc_back
  import obsc_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          job_valid,
  output logic                               job_pop,
  input  wire logic [2*(6*COORD_WIDTH-2+ANGLE_WIDTH)-1:0] job,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               collide,
  output logic signed [COORD_WIDTH-1:0]      push_x,
  output logic signed [COORD_WIDTH-1:0]      push_y
);

  localparam int C      = COORD_WIDTH;
  localparam int AW     = ANGLE_WIDTH;
  localparam int REC_W  = 6 * C - 2 + AW;
  localparam int ENT_W  = 2 * REC_W;
  localparam int TRIG   = TRIG_BASE - C;
  localparam int A_W    = TRIG + 3;
  localparam int CNR_W  = C + 4;
  localparam int PROD_W = A_W + CNR_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W + 1;
  localparam int OV_W   = SUM_W + 1;

  localparam logic signed [RND_W-1:0] HALF   = {{(RND_W-1){1'b0}}, 1'b1} <<< (TRIG - 1);
  localparam logic signed [RND_W-1:0] SAT_HI = {{(RND_W-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [RND_W-1:0] SAT_LO = {{(RND_W-C+1){1'b1}}, {(C-1){1'b0}}};

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TRIG   = 3'd1;
  localparam logic [2:0] S_CORNER = 3'd2;
  localparam logic [2:0] S_PROJ   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_ROUND  = 3'd5;
  localparam logic [2:0] S_PUSH   = 3'd6;
  localparam logic [2:0] S_WAIT   = 3'd7;

  localparam logic [1:0] PH_CORNER = 2'd0;
  localparam logic [1:0] PH_PROJ   = 2'd1;
  localparam logic [1:0] PH_PUSH   = 2'd2;

  logic [2:0]        state;
  logic [4:0]        j;
  logic [ENT_W-1:0]  work;

  logic signed [C-1:0]   px [2];
  logic signed [C-1:0]   py [2];
  logic signed [C-1:0]   ox [2];
  logic signed [C-1:0]   oy [2];
  logic [C-2:0]          wd [2];
  logic [C-2:0]          ht [2];
  logic [TURN_W-1:0]     job_turn [2];

  logic signed [A_W-1:0] trig_c [2];
  logic signed [A_W-1:0] trig_s [2];
  logic signed [A_W-1:0] cord_c [2];
  logic signed [A_W-1:0] cord_s [2];
  logic                  cord_done [2];
  logic signed [A_W-1:0] axx [4];
  logic signed [A_W-1:0] axy [4];

  logic signed [CNR_W-1:0] cx [2][4];
  logic signed [CNR_W-1:0] cy [2][4];

  genvar gr;
  generate
    for (gr = 0; gr < 2; gr++) begin : g_rect
      logic [REC_W-1:0] rw;
      logic [REC_W-1:0] rj;
      assign rw = work[(1-gr)*REC_W +: REC_W];
      assign rj = job[(1-gr)*REC_W +: REC_W];
      assign px[gr] = $signed(rw[AW+5*C-2 +: C]);
      assign py[gr] = $signed(rw[AW+4*C-2 +: C]);
      assign ox[gr] = $signed(rw[AW+3*C-2 +: C]);
      assign oy[gr] = $signed(rw[AW+2*C-2 +: C]);
      assign wd[gr] = rw[AW+C-1 +: C-1];
      assign ht[gr] = rw[AW +: C-1];
      assign job_turn[gr] = {rj[AW-1:0], {(TURN_W-AW){1'b0}}};

      obsc_cordic #(
        .COORD_WIDTH(C)
      ) u_cordic (
        .clk   (clk),
        .rst   (rst),
        .start (job_pop),
        .turn  (job_turn[gr]),
        .done  (cord_done[gr]),
        .cos_o (cord_c[gr]),
        .sin_o (cord_s[gr])
      );
    end
  endgenerate

  assign axx[0] = trig_c[0];
  assign axy[0] = -trig_s[0];
  assign axx[1] = trig_s[0];
  assign axy[1] = trig_c[0];
  assign axx[2] = trig_c[1];
  assign axy[2] = -trig_s[1];
  assign axx[3] = trig_s[1];
  assign axy[3] = trig_c[1];

  logic                    best_plus;
  logic [1:0]              best_k;
  logic signed [OV_W-1:0]  best;
  logic signed [CNR_W-1:0] best_r;
  logic signed [A_W-1:0]   best_ax;
  logic signed [A_W-1:0]   best_ay;

  assign best_ax = best_plus ? axx[best_k] : -axx[best_k];
  assign best_ay = best_plus ? axy[best_k] : -axy[best_k];

  logic                    issue;
  logic [1:0]              issue_ph;
  logic signed [A_W-1:0]   a0;
  logic signed [A_W-1:0]   a1;
  logic signed [CNR_W-1:0] b0;
  logic signed [CNR_W-1:0] b1;
  logic                    ir;
  logic [1:0]              ii;
  logic signed [CNR_W-1:0] dxv;
  logic signed [CNR_W-1:0] dyv;

  assign ir = (state == S_PROJ) ? j[2] : j[3];
  assign ii = (state == S_PROJ) ? j[1:0] : j[2:1];

  always_comb begin
    dxv = (ii == 2'd1 || ii == 2'd2) ?
          CNR_W'($signed({1'b0, wd[ir]}) - ox[ir]) : CNR_W'(-ox[ir]);
    dyv = ii[1] ? CNR_W'($signed({1'b0, ht[ir]}) - oy[ir]) : CNR_W'(-oy[ir]);
    issue    = 1'b0;
    issue_ph = PH_CORNER;
    a0 = '0;
    a1 = '0;
    b0 = '0;
    b1 = '0;
    case (state)
      S_CORNER: begin
        issue = 1'b1;
        a0 = trig_c[ir];
        if (!j[0]) begin
          b0 = dxv;
          a1 = trig_s[ir];
          b1 = dyv;
        end else begin
          b0 = dyv;
          a1 = -trig_s[ir];
          b1 = dxv;
        end
      end
      S_PROJ: begin
        issue    = 1'b1;
        issue_ph = PH_PROJ;
        a0 = axx[j[4:3]];
        b0 = cx[ir][ii];
        a1 = axy[j[4:3]];
        b1 = cy[ir][ii];
      end
      S_PUSH: begin
        issue    = 1'b1;
        issue_ph = PH_PUSH;
        a0 = j[0] ? best_ay : best_ax;
        b0 = best_r;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  logic                     m_valid;
  logic [1:0]               m_ph;
  logic [4:0]               m_j;
  logic signed [PROD_W-1:0] prod0;
  logic signed [PROD_W-1:0] prod1;
  logic signed [SUM_W-1:0]  sum;
  logic signed [RND_W-1:0]  rnd;
  logic signed [C-1:0]      sat;

  always_ff @(posedge clk) begin
    prod0 <= a0 * b0;
    prod1 <= a1 * b1;
    m_ph  <= issue_ph;
    m_j   <= j;
  end

  assign sum = SUM_W'(prod0) + SUM_W'(prod1);
  assign rnd = (RND_W'(sum) + HALF) >>> TRIG;

  always_comb begin
    if (rnd > SAT_HI) begin
      sat = SAT_HI[C-1:0];
    end else if (rnd < SAT_LO) begin
      sat = SAT_LO[C-1:0];
    end else begin
      sat = rnd[C-1:0];
    end
  end

  logic signed [SUM_W-1:0] mn [2];
  logic signed [SUM_W-1:0] mx [2];
  logic signed [SUM_W-1:0] mn_new;
  logic signed [SUM_W-1:0] mx_new;
  logic                    mr;

  assign mr     = m_j[2];
  assign mn_new = (m_j[1:0] == 2'd0 || sum < mn[mr]) ? sum : mn[mr];
  assign mx_new = (m_j[1:0] == 2'd0 || sum > mx[mr]) ? sum : mx[mr];

  logic                    e1_valid;
  logic [1:0]              e1_k;
  logic signed [SUM_W-1:0] amin;
  logic signed [SUM_W-1:0] amax;
  logic signed [SUM_W-1:0] bmin;
  logic signed [SUM_W-1:0] bmax;

  logic                    e2_valid;
  logic [1:0]              e2_k;
  logic                    e2_gap;
  logic signed [OV_W-1:0]  ovp;
  logic signed [OV_W-1:0]  ovn;

  logic                    e3_valid;
  logic [1:0]              e3_k;
  logic                    e3_gap;
  logic                    e3_plus;
  logic signed [OV_W-1:0]  e3_ov;

  logic                    f_plus;
  logic signed [OV_W-1:0]  f_ov;
  logic signed [OV_W-1:0]  g_ov;
  logic                    sep;
  logic                    have;
  logic signed [OV_W:0]    best_rnd;

  assign f_plus   = !e2_k[1];
  assign f_ov     = f_plus ? ovp : ovn;
  assign g_ov     = f_plus ? ovn : ovp;
  assign best_rnd = ($signed({best[OV_W-1], best}) + (OV_W+1)'(HALF)) >>> TRIG;

  always_ff @(posedge clk) begin
    if (m_valid && m_ph == PH_PROJ) begin
      mn[mr] <= mn_new;
      mx[mr] <= mx_new;
      if (mr && m_j[1:0] == 2'd3) begin
        amin <= mn_new;
        amax <= mx_new;
        bmin <= mn[0];
        bmax <= mx[0];
        e1_k <= m_j[4:3];
      end
    end
    if (e1_valid) begin
      e2_k   <= e1_k;
      e2_gap <= (bmax < amin) || (amax < bmin);
      ovp    <= OV_W'(bmax) - OV_W'(amin);
      ovn    <= OV_W'(amax) - OV_W'(bmin);
    end
    if (e2_valid) begin
      e3_k   <= e2_k;
      e3_gap <= e2_gap;
      if (g_ov < f_ov) begin
        e3_ov   <= g_ov;
        e3_plus <= !f_plus;
      end else begin
        e3_ov   <= f_ov;
        e3_plus <= f_plus;
      end
    end
    if (e3_valid && (!have || e3_ov < best)) begin
      best      <= e3_ov;
      best_k    <= e3_k;
      best_plus <= e3_plus;
    end
    if (m_valid && m_ph == PH_CORNER) begin
      if (!m_j[0]) begin
        cx[m_j[3]][m_j[2:1]] <= CNR_W'(px[m_j[3]]) + rnd[CNR_W-1:0];
      end else begin
        cy[m_j[3]][m_j[2:1]] <= CNR_W'(py[m_j[3]]) + rnd[CNR_W-1:0];
      end
    end
    if (job_pop) begin
      work <= job;
    end
    if (state == S_TRIG && cord_done[0]) begin
      trig_c[0] <= cord_c[0];
      trig_s[0] <= cord_s[0];
      trig_c[1] <= cord_c[1];
      trig_s[1] <= cord_s[1];
    end
    if (state == S_ROUND) begin
      best_r <= best_rnd[CNR_W-1:0];
    end
  end

  logic out_valid;

  assign job_pop = (state == S_IDLE) && job_valid && !out_valid;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      j         <= '0;
      m_valid   <= 1'b0;
      e1_valid  <= 1'b0;
      e2_valid  <= 1'b0;
      e3_valid  <= 1'b0;
      sep       <= 1'b0;
      have      <= 1'b0;
      out_valid <= 1'b0;
      collide   <= 1'b0;
      push_x    <= '0;
      push_y    <= '0;
    end else begin
      m_valid  <= issue;
      e1_valid <= m_valid && m_ph == PH_PROJ && mr && m_j[1:0] == 2'd3;
      e2_valid <= e1_valid;
      e3_valid <= e2_valid;
      if (e3_valid) begin
        have <= 1'b1;
        if (e3_gap) begin
          sep <= 1'b1;
        end
      end
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (m_valid && m_ph == PH_PUSH) begin
        if (!m_j[0]) begin
          push_x <= sat;
        end else begin
          push_y    <= sat;
          collide   <= 1'b1;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
      end
      case (state)
        S_IDLE: begin
          if (job_pop) begin
            sep   <= 1'b0;
            have  <= 1'b0;
            state <= S_TRIG;
          end
        end
        S_TRIG: begin
          if (cord_done[0]) begin
            j     <= '0;
            state <= S_CORNER;
          end
        end
        S_CORNER: begin
          j <= j + 1'b1;
          if (j == 5'd15) begin
            j     <= '0;
            state <= S_PROJ;
          end
        end
        S_PROJ: begin
          j <= j + 1'b1;
          if (j == 5'd31) begin
            j     <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          j <= j + 1'b1;
          if (j == 5'd4) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          j <= '0;
          if (sep) begin
            collide   <= 1'b0;
            push_x    <= '0;
            push_y    <= '0;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          j <= j + 1'b1;
          if (j[0]) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          j <= j;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/oriented_box_sat_collision_unit.sv -----
// Separating-axis collision test of two rotated rectangles in signed fixed point. An item
// with action 0 stores its rectangle as the reference and gives no result; an item with
// action 1 is tested against the reference held when it was taken and gives one result:
// collide, and the minimum separation vector (zero when there is no collision). Test items
// wait in a two-entry queue, so until the queue is full the input keeps taking items while
// a test runs and while a result waits to be popped. A test leaving the queue runs through
// two CORDIC units that produce sine and cosine of both angles side by side (30 iterations),
// then 50 dot products through one pair of multipliers (16 for the corners, 32 for the
// projections, 2 for the push vector; the last two are skipped when an axis shows a gap),
// then pipeline drain, rounding and registering of the push vector. A test starts only after
// the previous result is popped, so back-to-back tests do not overlap; their throughput is
// bound by the shared multiplier pair and the CORDIC iterations.
`timescale 1ns / 1ps
`default_nettype none
module oriented_box_sat_collision_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          action,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] pivot_x,
  input  wire logic signed [COORD_WIDTH-1:0] pivot_y,
  input  wire logic [COORD_WIDTH-2:0]        width,
  input  wire logic [COORD_WIDTH-2:0]        height,
  input  wire logic [ANGLE_WIDTH-1:0]        angle,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               collide,
  output logic signed [COORD_WIDTH-1:0]      push_x,
  output logic signed [COORD_WIDTH-1:0]      push_y
);

  localparam int ENT_W = 2 * (6 * COORD_WIDTH - 2 + ANGLE_WIDTH);

  logic             job_valid;
  logic             job_pop;
  logic [ENT_W-1:0] job;

  obsc_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pivot_x   (pivot_x),
    .pivot_y   (pivot_y),
    .width     (width),
    .height    (height),
    .angle     (angle),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  obsc_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job),
    .empty     (empty),
    .pop       (pop),
    .collide   (collide),
    .push_x    (push_x),
    .push_y    (push_y)
  );

  a_no_collide_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !collide) |-> (push_x == '0 && push_y == '0))
    else $error("separation vector not zero without collision");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> (empty && job_valid))
    else $error("test started while a result is pending");

  a_full_has_job: assert property (@(posedge clk) disable iff (rst)
    full |-> job_valid)
    else $error("queue full but no test waiting");

endmodule
`default_nettype wire
